// ----- hdl/rcs_pkg.sv -----
// Shared types and constants for the relay command scheduler.
// No dependencies; used by rcs_ctrl, rcs_datapath and relay_command_scheduler.
`timescale 1ns / 1ps

package rcs_pkg;

    localparam logic [3:0] RC_NONE     = 4'd0;
    localparam logic [3:0] RC_OK       = 4'd1;
    localparam logic [3:0] RC_MOTOR    = 4'd2;
    localparam logic [3:0] RC_TIMEOUT  = 4'd3;
    localparam logic [3:0] RC_DEFAULT  = 4'd4;
    localparam logic [3:0] RC_RELAYNUM = 4'd5;
    localparam logic [3:0] RC_SYMBOL   = 4'd6;
    localparam logic [3:0] RC_ONTIME   = 4'd7;
    localparam logic [3:0] RC_OFFTIME  = 4'd8;
    localparam logic [3:0] RC_GENERIC  = 4'd9;

    localparam logic [12:0] TIMEOUT_MAX_SEC   = 13'd3600;
    localparam logic [11:0] TIME_DIGIT_LIMIT  = 12'd200;
    localparam logic [8:0]  MOTOR_DIGIT_LIMIT = 9'd20;
    localparam logic [8:0]  SPEED_MAX         = 9'd100;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PM_IDLE, PM_MOTOR, PM_TIMER, PM_DEFAULT, PM_RELAY, PM_ONTIME, PM_OFFTIME
    } parse_mode_t;

    typedef enum logic [1:0] { DEF_NONE, DEF_OFF, DEF_ON } def_t;
    typedef enum logic [1:0] { RM_OFF, RM_ON, RM_SWITCH } relay_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PARSE, ST_APPLY, ST_TICK, ST_CLEAR, ST_OUT
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // load input beat
        logic parse;     // run one character through the parser
        logic apply_go;  // apply relay at walk index
        logic tick_go;   // tick relay at walk index
        logic tick_head; // timeout step (once per tick)
        logic finish;    // settle response, clear pending if asked
        logic walk_clr;  // zero walk index
        logic walk_inc;  // advance walk index
        logic load_out;  // copy the result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_char;
        logic walk_last;
        logic need_apply;
    } status_t;

endpackage

// ----- hdl/rcs_ctrl.sv -----
// Controller state machine for the relay command scheduler.
// Depends on rcs_pkg.
`timescale 1ns / 1ps

module rcs_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  rcs_pkg::status_t  status,
    output rcs_pkg::cmd_t     cmd
);

    rcs_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            rcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture  = 1'b1;
                    cmd.walk_clr = 1'b1;
                    state_next   = rcs_pkg::ST_PARSE;
                end
            end
            rcs_pkg::ST_PARSE:
            begin
                // tick: step timeout first; char: parse and decide on apply
                if (status.is_char)
                begin
                    cmd.parse = 1'b1;
                    state_next = rcs_pkg::ST_CLEAR;
                end
                else
                begin
                    cmd.tick_head = 1'b1;
                    state_next = rcs_pkg::ST_TICK;
                end
            end
            rcs_pkg::ST_CLEAR:
            begin
                state_next = status.need_apply ? rcs_pkg::ST_APPLY : rcs_pkg::ST_OUT;
                if (!status.need_apply)
                begin
                    cmd.finish = 1'b1;
                end
            end
            rcs_pkg::ST_APPLY:
            begin
                cmd.apply_go = 1'b1;
                cmd.walk_inc = 1'b1;
                if (status.walk_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = rcs_pkg::ST_OUT;
                end
            end
            rcs_pkg::ST_TICK:
            begin
                cmd.tick_go  = 1'b1;
                cmd.walk_inc = 1'b1;
                if (status.walk_last)
                begin
                    state_next = rcs_pkg::ST_OUT;
                end
            end
            rcs_pkg::ST_OUT:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = rcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rcs_pkg::ST_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !out_ready) || cmd.load_out;
    end

endmodule

// ----- hdl/rcs_datapath.sv -----
// Datapath for the relay command scheduler: parser, pending command,
// relay schedule, timeout and motor state. Depends on rcs_pkg.
`timescale 1ns / 1ps

module rcs_datapath
#(
    parameter int NUM_RELAYS        = 11,
    parameter int MAX_COMMAND_CHARS = 64,
    parameter int TICKS_PER_SECOND  = 1000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rcs_pkg::cmd_t         cmd,
    output rcs_pkg::status_t      status,
    input  logic                  opcode,
    input  logic [7:0]            char_code,
    input  logic [31:0]           tick_time,
    output logic [NUM_RELAYS-1:0] relay_drive,
    output logic [3:0]            response_code,
    output logic [6:0]            speed_pct,
    output logic                  motor_in_use
);

    localparam int IW = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
    localparam logic [6:0] CHAR_LIMIT = 7'(MAX_COMMAND_CHARS - 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_RELAYS - 1);
    localparam logic [6:0] NUM_R7 = 7'(NUM_RELAYS);

    // input beat
    logic        op_reg;
    logic [7:0]  ch_reg;
    logic [31:0] now_reg;

    // parser
    rcs_pkg::parse_mode_t mode_reg;
    logic [3:0]  dig0_reg, dig1_reg;
    logic [1:0]  dcnt_reg;
    logic [6:0]  ccnt_reg;
    logic        aborted_reg;
    logic [NUM_RELAYS-1:0] p_used_reg;
    logic [11:0] p_on_reg  [NUM_RELAYS];
    logic [11:0] p_off_reg [NUM_RELAYS];
    logic [IW-1:0] p_idx_reg;
    logic [8:0]  p_motor_reg;
    logic        p_mmen_reg;
    logic [12:0] p_tmo_reg;
    logic        p_tgiven_reg;
    rcs_pkg::def_t p_def_reg;

    // schedule
    rcs_pkg::relay_mode_t rmode_reg [NUM_RELAYS];
    logic [11:0] ron_reg  [NUM_RELAYS];
    logic [11:0] roff_reg [NUM_RELAYS];
    logic [NUM_RELAYS-1:0] pos_reg;
    logic [31:0] last_reg [NUM_RELAYS];
    logic [21:0] tcnt_reg;
    logic        mused_reg;
    logic [6:0]  mspeed_reg;

    logic [IW-1:0] walk_reg;
    logic [3:0]  rc_reg;
    logic        need_apply_reg;
    logic        clear_reg;   // clear pending at finish
    logic        expire_reg;  // timeout expired during this tick

    // output register
    logic [NUM_RELAYS-1:0] drive_out_reg;
    logic [3:0]  code_out_reg;
    logic [6:0]  speed_out_reg;
    logic        in_use_out_reg;

    // parse combinational
    logic        is_dig;
    logic [3:0]  d;
    logic [3:0]  prc;
    logic [12:0] tmo_sum;
    logic [6:0]  rnum;

    assign is_dig = (ch_reg >= rcs_pkg::CH_ZERO) && (ch_reg <= rcs_pkg::CH_NINE);
    assign d      = ch_reg[3:0];
    assign tmo_sum = 13'(p_tmo_reg * 13'd10) + 13'(d);
    assign rnum   = (dcnt_reg == 2'd0) ? 7'd0 :
                    (dcnt_reg == 2'd1) ? {3'b0, dig0_reg} :
                    7'(dig0_reg * 7'd10) + {3'b0, dig1_reg};

    always_comb
    begin
        prc = rcs_pkg::RC_NONE;
        unique case (mode_reg)
            rcs_pkg::PM_IDLE: prc = rcs_pkg::RC_NONE;
            rcs_pkg::PM_MOTOR:
                if (ch_reg == rcs_pkg::CH_BAR) prc = rcs_pkg::RC_NONE;
                else if (!is_dig) prc = rcs_pkg::RC_GENERIC;
                else if (p_motor_reg > rcs_pkg::MOTOR_DIGIT_LIMIT) prc = rcs_pkg::RC_MOTOR;
            rcs_pkg::PM_TIMER:
                if (ch_reg == rcs_pkg::CH_BAR) prc = rcs_pkg::RC_NONE;
                else if (!is_dig) prc = rcs_pkg::RC_GENERIC;
                else if ({4'd0, p_tmo_reg} * 17'd10 + 17'(d) > 17'(rcs_pkg::TIMEOUT_MAX_SEC))
                    prc = rcs_pkg::RC_TIMEOUT;
            rcs_pkg::PM_DEFAULT:
                if (ch_reg != rcs_pkg::CH_BAR && ch_reg != rcs_pkg::CH_PLUS
                    && ch_reg != rcs_pkg::CH_MINUS) prc = rcs_pkg::RC_DEFAULT;
            rcs_pkg::PM_RELAY:
                if (ch_reg == rcs_pkg::CH_BAR || ch_reg == rcs_pkg::CH_SLASH)
                begin
                    if (rnum < 7'd1 || rnum > NUM_R7) prc = rcs_pkg::RC_RELAYNUM;
                end
                else if (!is_dig) prc = rcs_pkg::RC_SYMBOL;
                else if (dcnt_reg >= 2'd2) prc = rcs_pkg::RC_RELAYNUM;
            rcs_pkg::PM_ONTIME:
                if (ch_reg == rcs_pkg::CH_SLASH) prc = rcs_pkg::RC_NONE;
                else if (!is_dig) prc = rcs_pkg::RC_SYMBOL;
                else if (p_on_reg[p_idx_reg] > rcs_pkg::TIME_DIGIT_LIMIT)
                    prc = rcs_pkg::RC_ONTIME;
            rcs_pkg::PM_OFFTIME:
                if (ch_reg == rcs_pkg::CH_BAR) prc = rcs_pkg::RC_NONE;
                else if (!is_dig) prc = rcs_pkg::RC_SYMBOL;
                else if (p_off_reg[p_idx_reg] > rcs_pkg::TIME_DIGIT_LIMIT)
                    prc = rcs_pkg::RC_OFFTIME;
            default: prc = rcs_pkg::RC_GENERIC;
        endcase
    end

    assign status.is_char    = op_reg;
    assign status.walk_last  = (walk_reg == LAST_IDX);
    assign status.need_apply = need_apply_reg;

    // tick walk terms
    logic [31:0] span, lim;
    assign span = pos_reg[walk_reg] ? {20'd0, ron_reg[walk_reg]} : {20'd0, roff_reg[walk_reg]};
    assign lim  = last_reg[walk_reg] + span;

    // apply terms
    logic [11:0] a_on, a_off;
    assign a_on  = p_on_reg[walk_reg];
    assign a_off = p_off_reg[walk_reg];

    // beat capture and pure payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            ch_reg  <= char_code;
            now_reg <= tick_time;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= rcs_pkg::PM_IDLE;
            dig0_reg <= '0; dig1_reg <= '0; dcnt_reg <= '0; ccnt_reg <= '0;
            aborted_reg <= 1'b0;
            p_used_reg <= '0;
            for (int i = 0; i < NUM_RELAYS; i++)
            begin
                p_on_reg[i] <= '0; p_off_reg[i] <= '0;
                rmode_reg[i] <= rcs_pkg::RM_OFF;
                ron_reg[i] <= '0; roff_reg[i] <= '0; last_reg[i] <= '0;
            end
            p_idx_reg <= '0; p_motor_reg <= '0; p_mmen_reg <= 1'b0;
            p_tmo_reg <= '0; p_tgiven_reg <= 1'b0; p_def_reg <= rcs_pkg::DEF_NONE;
            pos_reg <= '0; tcnt_reg <= '0; mused_reg <= 1'b0; mspeed_reg <= '0;
            walk_reg <= '0; rc_reg <= rcs_pkg::RC_NONE;
            need_apply_reg <= 1'b0; clear_reg <= 1'b0; expire_reg <= 1'b0;
            drive_out_reg <= '0; code_out_reg <= rcs_pkg::RC_NONE;
            speed_out_reg <= '0; in_use_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.walk_clr)
            begin
                walk_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                walk_reg <= (walk_reg == LAST_IDX) ? '0 : walk_reg + 1'b1;
            end

            if (cmd.capture)
            begin
                rc_reg <= rcs_pkg::RC_NONE;
                need_apply_reg <= 1'b0;
                clear_reg <= 1'b0;
                expire_reg <= 1'b0;
            end

            if (cmd.parse)
            begin
                if (aborted_reg)
                begin
                    if (ch_reg == rcs_pkg::CH_SEMI)
                    begin
                        clear_reg <= 1'b1;
                        aborted_reg <= 1'b0;
                    end
                end
                else if (ch_reg == rcs_pkg::CH_SEMI)
                begin
                    need_apply_reg <= 1'b1; clear_reg <= 1'b1; rc_reg <= rcs_pkg::RC_OK;
                end
                else
                begin
                    ccnt_reg <= ccnt_reg + 7'd1;
                    if (prc != rcs_pkg::RC_NONE)
                    begin
                        rc_reg <= prc; clear_reg <= 1'b1; aborted_reg <= 1'b1;
                    end
                    else
                    begin
                        if (ccnt_reg + 7'd1 >= CHAR_LIMIT)
                        begin
                            need_apply_reg <= 1'b1; clear_reg <= 1'b1;
                            aborted_reg <= 1'b1; rc_reg <= rcs_pkg::RC_OK;
                        end
                        // legal character: update pending command
                        unique case (mode_reg)
                            rcs_pkg::PM_IDLE:
                                if (ch_reg == rcs_pkg::CH_M) mode_reg <= rcs_pkg::PM_MOTOR;
                                else if (ch_reg == rcs_pkg::CH_T) mode_reg <= rcs_pkg::PM_TIMER;
                                else if (ch_reg == rcs_pkg::CH_A) mode_reg <= rcs_pkg::PM_DEFAULT;
                                else if (is_dig)
                                begin
                                    dig0_reg <= d; dcnt_reg <= 2'd1;
                                    mode_reg <= rcs_pkg::PM_RELAY;
                                end
                            rcs_pkg::PM_MOTOR:
                                if (ch_reg == rcs_pkg::CH_BAR) mode_reg <= rcs_pkg::PM_IDLE;
                                else
                                begin
                                    p_mmen_reg <= 1'b1;
                                    p_motor_reg <= 9'(p_motor_reg * 9'd10) + 9'(d);
                                end
                            rcs_pkg::PM_TIMER:
                                if (ch_reg == rcs_pkg::CH_BAR) mode_reg <= rcs_pkg::PM_IDLE;
                                else
                                begin
                                    p_tgiven_reg <= 1'b1; p_tmo_reg <= tmo_sum;
                                end
                            rcs_pkg::PM_DEFAULT:
                                if (ch_reg == rcs_pkg::CH_BAR) mode_reg <= rcs_pkg::PM_IDLE;
                                else if (ch_reg == rcs_pkg::CH_PLUS) p_def_reg <= rcs_pkg::DEF_ON;
                                else p_def_reg <= rcs_pkg::DEF_OFF;
                            rcs_pkg::PM_RELAY:
                                if (ch_reg == rcs_pkg::CH_BAR || ch_reg == rcs_pkg::CH_SLASH)
                                begin
                                    dcnt_reg <= 2'd0;
                                    p_used_reg[IW'(rnum - 7'd1)] <= 1'b1;
                                    p_idx_reg <= IW'(rnum - 7'd1);
                                    mode_reg <= (ch_reg == rcs_pkg::CH_BAR) ?
                                                rcs_pkg::PM_IDLE : rcs_pkg::PM_ONTIME;
                                end
                                else
                                begin
                                    if (dcnt_reg == 2'd0) dig0_reg <= d;
                                    else dig1_reg <= d;
                                    dcnt_reg <= dcnt_reg + 2'd1;
                                end
                            rcs_pkg::PM_ONTIME:
                                if (ch_reg == rcs_pkg::CH_SLASH) mode_reg <= rcs_pkg::PM_OFFTIME;
                                else p_on_reg[p_idx_reg] <=
                                         12'(p_on_reg[p_idx_reg] * 12'd10) + 12'(d);
                            rcs_pkg::PM_OFFTIME:
                                if (ch_reg == rcs_pkg::CH_BAR) mode_reg <= rcs_pkg::PM_IDLE;
                                else p_off_reg[p_idx_reg] <=
                                         12'(p_off_reg[p_idx_reg] * 12'd10) + 12'(d);
                            default: mode_reg <= rcs_pkg::PM_IDLE;
                        endcase
                    end
                end
            end

            if (cmd.apply_go)
            begin
                if (p_used_reg[walk_reg])
                begin
                    if (a_on != 12'd0 && a_off != 12'd0)
                    begin
                        rmode_reg[walk_reg] <= rcs_pkg::RM_SWITCH;
                        ron_reg[walk_reg] <= a_on; roff_reg[walk_reg] <= a_off;
                    end
                    else if (a_on == 12'd0 && a_off != 12'd0)
                        rmode_reg[walk_reg] <= rcs_pkg::RM_OFF;
                    else
                        rmode_reg[walk_reg] <= rcs_pkg::RM_ON;
                end
                else if (p_def_reg == rcs_pkg::DEF_OFF) rmode_reg[walk_reg] <= rcs_pkg::RM_OFF;
                else if (p_def_reg == rcs_pkg::DEF_ON) rmode_reg[walk_reg] <= rcs_pkg::RM_ON;
                if (walk_reg == LAST_IDX)
                begin
                    if (p_tgiven_reg)
                        tcnt_reg <= 22'(p_tmo_reg * 22'(TICKS_PER_SECOND)) + 22'd1;
                    if (p_mmen_reg)
                    begin
                        mused_reg <= 1'b1;
                        mspeed_reg <= (p_motor_reg > rcs_pkg::SPEED_MAX) ?
                                      7'(rcs_pkg::SPEED_MAX) : p_motor_reg[6:0];
                    end
                end
            end

            if (cmd.finish && clear_reg)
            begin
                mode_reg <= rcs_pkg::PM_IDLE;
                dig0_reg <= '0; dig1_reg <= '0; dcnt_reg <= '0; ccnt_reg <= '0;
                p_used_reg <= '0;
                for (int i = 0; i < NUM_RELAYS; i++)
                begin
                    p_on_reg[i] <= '0; p_off_reg[i] <= '0;
                end
                p_idx_reg <= '0; p_motor_reg <= '0; p_mmen_reg <= 1'b0;
                p_tmo_reg <= '0; p_tgiven_reg <= 1'b0; p_def_reg <= rcs_pkg::DEF_NONE;
            end

            if (cmd.tick_head && tcnt_reg != 22'd0)
            begin
                if (tcnt_reg == 22'd1)
                begin
                    expire_reg <= 1'b1;
                    tcnt_reg <= '0;
                    if (mused_reg) mspeed_reg <= '0;
                end
                else tcnt_reg <= tcnt_reg - 22'd1;
            end

            if (cmd.tick_go)
            begin
                // expiry clears relays before the walk sees them
                if (expire_reg || rmode_reg[walk_reg] == rcs_pkg::RM_OFF)
                begin
                    rmode_reg[walk_reg] <= rcs_pkg::RM_OFF;
                    pos_reg[walk_reg] <= 1'b0;
                    if (expire_reg) last_reg[walk_reg] <= '0;
                end
                else if (rmode_reg[walk_reg] == rcs_pkg::RM_ON)
                    pos_reg[walk_reg] <= 1'b1;
                else if (now_reg > lim)
                begin
                    last_reg[walk_reg] <= now_reg;
                    pos_reg[walk_reg] <= ~pos_reg[walk_reg];
                end
            end

            if (cmd.load_out)
            begin
                drive_out_reg  <= pos_reg;
                code_out_reg   <= rc_reg;
                speed_out_reg  <= mspeed_reg;
                in_use_out_reg <= mused_reg;
            end
        end
    end

    assign relay_drive   = drive_out_reg;
    assign response_code = code_out_reg;
    assign speed_pct     = speed_out_reg;
    assign motor_in_use  = in_use_out_reg;

endmodule

// ----- hdl/relay_command_scheduler.sv -----
// Top level of the relay command scheduler.
// Depends on rcs_pkg, rcs_ctrl and rcs_datapath.
`timescale 1ns / 1ps
//
// Use: one input channel (in_valid/in_ready) carries beats that are either
// a millisecond tick (opcode 0, tick_time) or one RUN command character
// (opcode 1, char_code). Every input beat yields exactly one output beat on
// out_valid/out_ready: relay drive bits, response code, motor speed and the
// motor-in-use flag, all as they stand after the beat.
//
// Sequence, from input acceptance to the result in the output register: a
// tick takes one timeout step, then a walk over the relays, one relay a
// cycle. A character is parsed and then checked for apply; when it applies
// the command, an apply walk also visits one relay per cycle. One item is
// worked on at a time; the next beat is taken once the result has moved
// into the output register.
//
// Reset: all relays always off, no timeout, motor not in use, parser idle.
// Stall: the result holds in the output register until taken; the next
// item is still worked on, and its result waits until the register frees.

module relay_command_scheduler
#(
    parameter int NUM_RELAYS        = 11,
    parameter int MAX_COMMAND_CHARS = 64,
    parameter int TICKS_PER_SECOND  = 1000
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [7:0]            char_code,
    input  logic [31:0]           tick_time,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [NUM_RELAYS-1:0] relay_drive,
    output logic [3:0]            response_code,
    output logic [6:0]            speed_pct,
    output logic                  motor_in_use
);

    rcs_pkg::cmd_t    cmd;
    rcs_pkg::status_t status;

    // sequence each beat
    rcs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // hold parser, schedule and outputs
    rcs_datapath #(
        .NUM_RELAYS        (NUM_RELAYS),
        .MAX_COMMAND_CHARS (MAX_COMMAND_CHARS),
        .TICKS_PER_SECOND  (TICKS_PER_SECOND)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .opcode        (opcode),
        .char_code     (char_code),
        .tick_time     (tick_time),
        .relay_drive   (relay_drive),
        .response_code (response_code),
        .speed_pct     (speed_pct),
        .motor_in_use  (motor_in_use)
    );

endmodule
